// ===== src/dcsf_pkg.sv =====
// dcsf_pkg: shared types, sequence positions and the output byte lookup
// for the dle stuffing framer; no dependencies
`timescale 1ns / 1ps

package dcsf_pkg;

   localparam logic [7:0] CH_D = 8'h44;
   localparam logic [7:0] CH_L = 8'h4C;
   localparam logic [7:0] CH_E = 8'h45;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_T = 8'h54;
   localparam logic [7:0] CH_X = 8'h58;

   // match progress codes
   typedef enum logic [1:0] {
      MATCH_NONE = 2'd0,
      MATCH_D    = 2'd1,
      MATCH_DL   = 2'd2
   } dcsf_match_type;

   // positions along the full output sequence of one item
   typedef logic [3:0] dcsf_pos_type;
   localparam dcsf_pos_type POS_START_FIRST = 4'd0;
   localparam dcsf_pos_type POS_START_LAST  = 4'd5;
   localparam dcsf_pos_type POS_PAYLOAD     = 4'd6;
   localparam dcsf_pos_type POS_STUFF_LAST  = 4'd9;
   localparam dcsf_pos_type POS_END_FIRST   = 4'd10;
   localparam dcsf_pos_type POS_END_LAST    = 4'd15;

   // classified item handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start;
      logic       stuff;
      logic       fin;
   } dcsf_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } dcsf_fifo_stat_type;

   typedef struct packed {
      logic         busy;
      dcsf_pos_type pos;
   } dcsf_back_stat_type;

   // byte emitted at a given sequence position
   function automatic logic [7:0] seq_byte(input dcsf_pos_type pos, input logic [7:0] data);
      logic [7:0] b;
      unique case (pos)
         4'd0, 4'd7, 4'd10: b = CH_D;
         4'd1, 4'd8, 4'd11: b = CH_L;
         4'd2, 4'd9, 4'd12, 4'd13: b = CH_E;
         4'd3:              b = CH_S;
         4'd4, 4'd14:       b = CH_T;
         4'd5, 4'd15:       b = CH_X;
         4'd6:              b = data;
         default:           b = data;
      endcase
      return b;
   endfunction

endpackage

// ===== src/dcsf_front.sv =====
// dcsf_front: accepts payload items, tracks frame and match state and
// classifies each item into a descriptor; depends on dcsf_pkg
`timescale 1ns / 1ps

module dcsf_front
   import dcsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   input  logic          push_ready,
   output logic          push_valid,
   output dcsf_desc_type push_desc,
   output logic          in_frame
);

   logic           in_frame_ff, in_frame_in;
   dcsf_match_type match_ff, match_in;
   logic           accept;
   logic           matched;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign push_valid = accept;
   assign in_frame   = in_frame_ff;

   // match tracking; a fresh frame starts from no progress
   always_comb begin
      dcsf_match_type prog;
      prog     = in_frame_ff ? match_ff : MATCH_NONE;
      matched  = 1'b0;
      match_in = MATCH_NONE;
      priority if (req_tdata == CH_D) begin
         match_in = MATCH_D;
      end else if (req_tdata == CH_L && prog == MATCH_D) begin
         match_in = MATCH_DL;
      end else if (req_tdata == CH_E && prog == MATCH_DL) begin
         matched  = 1'b1;
         match_in = MATCH_NONE;
      end else begin
         match_in = MATCH_NONE;
      end
      if (req_tlast) begin
         match_in = MATCH_NONE;
      end
      in_frame_in = !req_tlast;
   end

   // descriptor for the back end
   always_comb begin
      push_desc.data_byte = req_tdata;
      push_desc.start     = !in_frame_ff;
      push_desc.stuff     = matched;
      push_desc.fin       = req_tlast;
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         match_ff    <= MATCH_NONE;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         match_ff    <= match_in;
      end
   end

endmodule

// ===== src/dcsf_fifo.sv =====
// dcsf_fifo: short descriptor queue between front and back
// depends on dcsf_pkg
`timescale 1ns / 1ps

module dcsf_fifo
   import dcsf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dcsf_desc_type      push_desc,
   input  logic               pop,
   output dcsf_desc_type      head_desc,
   output dcsf_fifo_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   dcsf_desc_type   entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head_desc = entry_ff[rd_ptr_ff];
   assign stat      = '{empty: (count_ff == '0), full: (count_ff == FULL_CNT)};

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== src/dcsf_back.sv =====
// dcsf_back: walks each descriptor through flag, payload and stuffing
// bytes into the output register; depends on dcsf_pkg
`timescale 1ns / 1ps

module dcsf_back
   import dcsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  dcsf_desc_type      head_desc,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output dcsf_back_stat_type stat
);

   logic         busy_ff, busy_in;
   dcsf_pos_type pos_ff, pos_in;
   logic         valid_ff, valid_in;
   logic [7:0]   byte_ff;
   logic         last_ff;
   dcsf_pos_type cur_pos;
   logic         emit;
   logic         is_last;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign stat       = '{busy: busy_ff, pos: pos_ff};

   assign cur_pos = busy_ff ? pos_ff : (head_desc.start ? POS_START_FIRST : POS_PAYLOAD);
   assign emit    = head_valid && (!valid_ff || rsp_tready);
   assign pop     = emit && is_last;

   // next position and end of item
   always_comb begin
      is_last = 1'b0;
      pos_in  = cur_pos + 1'b1;
      priority if (cur_pos == POS_PAYLOAD) begin
         if (head_desc.stuff) begin
            pos_in = cur_pos + 1'b1;
         end else if (head_desc.fin) begin
            pos_in = POS_END_FIRST;
         end else begin
            is_last = 1'b1;
         end
      end else if (cur_pos == POS_STUFF_LAST) begin
         if (!head_desc.fin) begin
            is_last = 1'b1;
         end
      end else if (cur_pos == POS_END_LAST) begin
         is_last = 1'b1;
      end else begin
         pos_in = cur_pos + 1'b1;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      if (emit) begin
         busy_in  = !is_last;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         pos_ff   <= POS_START_FIRST;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         if (emit) begin
            pos_ff <= pos_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= seq_byte(cur_pos, head_desc.data_byte);
         last_ff <= is_last;
      end
   end

endmodule

// ===== src/dle_character_stuffing_framer_unit.sv =====
// dle stuffing framer: one payload byte in, 1 to 16 framed bytes out
// an item is held in the queue, then registered in the back end output
// throughput: one output byte per cycle, set by the back end sequencer,
//   while the queue holds an item and the receiver is ready
// reset: synchronous, active high; clears frame state, queue and output
// depends on dcsf_pkg, dcsf_front, dcsf_fifo, dcsf_back
`timescale 1ns / 1ps

module dle_character_stuffing_framer_unit
   import dcsf_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // frame_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   logic               push_valid;
   dcsf_desc_type      push_desc;
   logic               in_frame;
   logic               pop;
   dcsf_desc_type      head_desc;
   dcsf_fifo_stat_type fifo_stat;
   dcsf_back_stat_type back_stat;

   // front end: classify
   dcsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_ready (!fifo_stat.full),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .in_frame   (in_frame)
   );

   // descriptor queue
   dcsf_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .stat      (fifo_stat)
   );

   // back end: emit bytes
   dcsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!fifo_stat.empty),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .stat       (back_stat)
   );

   // a partly sent item stays at the queue head
   assert property (@(posedge clock) disable iff (reset)
      back_stat.busy |-> !fifo_stat.empty)
      else $error("back end busy with an empty queue");

   // end flag positions are only reached by a frame end item
   assert property (@(posedge clock) disable iff (reset)
      (back_stat.busy && back_stat.pos >= POS_END_FIRST) |-> head_desc.fin)
      else $error("end flag sent for an item that does not close the frame");

   // a frame end item leaves the front out of frame
   assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_desc.fin) |=> !in_frame)
      else $error("frame state not closed after frame end");

   // the back end pops only a queued item
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("pop from empty queue");

endmodule

// ===== test/tb_dle_character_stuffing_framer_unit.sv =====
// tb_dle_character_stuffing_framer_unit: self-checking bench for the dle stuffing framer;
// streams payload frames in, predicts the framed byte stream, compares every output item
// depends on dcsf_pkg and dle_character_stuffing_framer_unit
`timescale 1ns / 1ps

module tb_dle_character_stuffing_framer_unit;
   import dcsf_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 20;

   // one payload item offered on the input channel
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } payload_item_type;

   // one framed byte expected on the output channel
   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } framed_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // [7:0] data_byte
   logic       req_tlast = 1'b0; // frame_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [7:0] out_byte
   logic       rsp_tlast;        // out_last

   payload_item_type pending_items[$];
   framed_item_type  framed_expect[$];

   // framer state as predicted
   logic           pred_in_frame = 1'b0;
   dcsf_match_type pred_match = MATCH_NONE;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   error_count = 0;
   logic req_taken = 1'b0;

   dle_character_stuffing_framer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // framed bytes caused by one payload item, appended to the expected stream
   task automatic predict_framed_bytes(input logic [7:0] ch, input logic fin);
      logic [7:0] seq[$];
      logic       stuff;
      stuff = 1'b0;
      if (!pred_in_frame) begin
         seq = '{CH_D, CH_L, CH_E, CH_S, CH_T, CH_X};
         pred_in_frame = 1'b1;
         pred_match = MATCH_NONE;
      end
      seq.push_back(ch);
      // a 'D' always restarts the match; matches never overlap
      if (ch == CH_D)
         pred_match = MATCH_D;
      else if (ch == CH_L && pred_match == MATCH_D)
         pred_match = MATCH_DL;
      else if (ch == CH_E && pred_match == MATCH_DL) begin
         stuff = 1'b1;
         pred_match = MATCH_NONE;
      end else
         pred_match = MATCH_NONE;
      if (stuff) begin
         seq.push_back(CH_D);
         seq.push_back(CH_L);
         seq.push_back(CH_E);
      end
      if (fin) begin
         seq.push_back(CH_D);
         seq.push_back(CH_L);
         seq.push_back(CH_E);
         seq.push_back(CH_E);
         seq.push_back(CH_T);
         seq.push_back(CH_X);
         pred_in_frame = 1'b0;
         pred_match = MATCH_NONE;
      end
      foreach (seq[i])
         framed_expect.push_back('{seq[i], (i == seq.size() - 1)});
   endtask

   // random frames, mostly built from dle runs so stuffing happens often
   task automatic queue_random_frames(input int n_items);
      int         added;
      int         len;
      logic [7:0] frame[$];
      logic [7:0] ch;
      added = 0;
      while (added < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         frame.delete();
         while (frame.size() < len) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  frame.push_back(CH_D);
                  frame.push_back(CH_L);
                  frame.push_back(CH_E);
               end
               3: begin
                  frame.push_back(CH_D);
                  frame.push_back(CH_D);
                  frame.push_back(CH_L);
                  frame.push_back(CH_E);
               end
               4, 5: begin
                  case ($urandom_range(0, 2))
                     0: ch = CH_D;
                     1: ch = CH_L;
                     default: ch = CH_E;
                  endcase
                  frame.push_back(ch);
               end
               default: frame.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         foreach (frame[i])
            pending_items.push_back('{frame[i], (i == frame.size() - 1)});
         added += frame.size();
      end
   endtask

   // input driver: holds an offered item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         if (req_taken)
            void'(pending_items.pop_front());
         if (req_tvalid && !req_taken) begin
            // keep offering the same item
         end else if (pending_items.size() != 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_items[0].data;
            req_tlast <= pending_items[0].fin;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // output ready driver
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_served <= hold_requests;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: checks output items and predicts from accepted input items
   always @(posedge clock) begin
      framed_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (framed_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected item byte %02h last %0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = framed_expect.pop_front();
               if (rsp_tdata !== want.out_char)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_tdata, want.out_char));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("out_last %0b, want %0b",
                                            rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready)
            predict_framed_bytes(req_tdata, req_tlast);
         req_taken <= req_tvalid && req_tready;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stimulus sequencing
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one-byte frames with all-zero and all-one bytes
      pending_items.push_back('{8'h00, 1'b1});
      pending_items.push_back('{8'hFF, 1'b1});
      // plain match followed by payload
      pending_items.push_back('{CH_D, 1'b0});
      pending_items.push_back('{CH_L, 1'b0});
      pending_items.push_back('{CH_E, 1'b0});
      pending_items.push_back('{8'h55, 1'b1});
      // repeated d, match on the frame's last byte
      pending_items.push_back('{CH_D, 1'b0});
      pending_items.push_back('{CH_D, 1'b0});
      pending_items.push_back('{CH_L, 1'b0});
      pending_items.push_back('{CH_E, 1'b1});
      // no overlap after a match
      pending_items.push_back('{CH_D, 1'b0});
      pending_items.push_back('{CH_L, 1'b0});
      pending_items.push_back('{CH_E, 1'b0});
      pending_items.push_back('{CH_L, 1'b0});
      pending_items.push_back('{CH_E, 1'b0});
      pending_items.push_back('{8'hAA, 1'b1});
      // match cut by a frame boundary
      pending_items.push_back('{CH_D, 1'b0});
      pending_items.push_back('{CH_L, 1'b1});
      pending_items.push_back('{CH_E, 1'b1});
      // partial sequences that must not stuff
      pending_items.push_back('{CH_L, 1'b0});
      pending_items.push_back('{CH_E, 1'b0});
      pending_items.push_back('{CH_D, 1'b0});
      pending_items.push_back('{CH_E, 1'b1});

      // no idling
      queue_random_frames(85);
      while (pending_items.size() != 0) @(posedge clock);
      // sender pauses until the stream has drained
      while (framed_expect.size() != 0) @(posedge clock);

      // sender idles
      send_idle_pct = 58;
      queue_random_frames(85);
      while (pending_items.size() != 0) @(posedge clock);

      // receiver stalls
      send_idle_pct = 0;
      recv_stall_pct = 58;
      queue_random_frames(85);
      while (pending_items.size() != 0) @(posedge clock);

      // both idle, opening with a long receiver hold-off so the block backs up
      send_idle_pct = 31;
      recv_stall_pct = 31;
      @(negedge clock);
      hold_requests++;
      queue_random_frames(85);
      while (pending_items.size() != 0) @(posedge clock);

      while (framed_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dcsf_pkg.sv
src/dcsf_front.sv
src/dcsf_fifo.sv
src/dcsf_back.sv
src/dle_character_stuffing_framer_unit.sv
test/tb_dle_character_stuffing_framer_unit.sv
